// File: sv/arp_cache_with_aging_core_macros.svh
// ----------------------------------------------------------------------------
// ARP cache assertion macros
// Concurrent assertion wrappers for the ARP cache back end.
// ----------------------------------------------------------------------------
`ifndef ARP_CACHE_WITH_AGING_CORE_MACROS_SVH
`define ARP_CACHE_WITH_AGING_CORE_MACROS_SVH

// assertion sampled on the rising clock, off while reset is high
`define ARP_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// assertion that also holds during reset
`define ARP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/arp_pkg.sv
// ----------------------------------------------------------------------------
// ARP cache package
// Sizes, request codes and the queued request type.
// ----------------------------------------------------------------------------
`default_nettype none

package arp_pkg;

  localparam int ENTRIES = 8;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [7:0] LIFETIME_RESET = 8'h80;

  localparam logic [1:0] REQ_LEARN  = 2'd0;
  localparam logic [1:0] REQ_LOOKUP = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] ip_addr;
    logic [47:0] mac_addr;
  } req_t;

endpackage

`default_nettype wire

// File: sv/arp_if.sv
// ----------------------------------------------------------------------------
// ARP cache channels
// Request, response and configuration write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface arp_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] ip_addr;
  logic [47:0] mac_addr;
  modport source (output valid, output req_type, output ip_addr, output mac_addr,
                  input ready);
  modport sink   (input valid, input req_type, input ip_addr, input mac_addr,
                  output ready);
endinterface

interface arp_rsp_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [47:0] mac_out;
  modport source (output valid, output found, output mac_out, input ready);
  modport sink   (input valid, input found, input mac_out, output ready);
endinterface

interface arp_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: sv/arp_cache_with_aging_core.sv
// ----------------------------------------------------------------------------
// ARP cache with aging, top level
// Lookup response is registered after the request passes the queue and the execute state.
// The back end pops a new request only after it has executed the last one.
// Synchronous reset clears valid bits, pointers and queue; reload value to 0x80.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_cache_with_aging_core
  import arp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  arp_req_if.sink   req,
  arp_rsp_if.source rsp,
  arp_cfg_if.sink   cfg
);

  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  req_t q_in;
  req_t q_out;

  arp_front u_front (
    .req    (req),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_in)
  );

  arp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  arp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_out),
    .q_pop   (q_pop),
    .cfg     (cfg),
    .rsp     (rsp)
  );

endmodule

`default_nettype wire

// File: sv/arp_front.sv
// ----------------------------------------------------------------------------
// ARP cache front end
// Takes requests, drops unused codes and pushes the rest into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_front
  import arp_pkg::*;
(
  arp_req_if.sink    req,
  input  wire logic  q_full,
  output logic       q_push,
  output req_t       q_data
);

  logic keep;

  assign keep     = req.req_type inside {REQ_LEARN, REQ_LOOKUP, REQ_TICK};
  // unused code is taken and dropped without reaching the back end
  assign req.ready = !q_full;
  assign q_push   = req.valid && !q_full && keep;

  assign q_data.req_type = req.req_type;
  assign q_data.ip_addr  = req.ip_addr;
  assign q_data.mac_addr = req.mac_addr;

endmodule

`default_nettype wire

// File: sv/arp_queue.sv
// ----------------------------------------------------------------------------
// ARP cache request queue
// Short FIFO between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_queue
  import arp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire req_t push_data,
  output logic      full,
  input  wire logic pop,
  output req_t      pop_data,
  output logic      empty
);

  req_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full     = (count == QCNT_W'(QDEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/arp_back.sv
// ----------------------------------------------------------------------------
// ARP cache back end
// Holds the table, runs learn, lookup and aging tick, drives responses.
// ----------------------------------------------------------------------------
`default_nettype none

`include "arp_cache_with_aging_core_macros.svh"

module arp_back
  import arp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic q_empty,
  input  wire req_t q_data,
  output logic      q_pop,
  arp_cfg_if.sink   cfg,
  arp_rsp_if.source rsp
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic              state;
  req_t              op;
  logic [7:0]        lifetime_reload;

  logic [ENTRIES-1:0] entry_valid;
  logic [7:0]         entry_lifetime [ENTRIES];
  logic [31:0]        entry_ip       [ENTRIES];
  logic [47:0]        entry_mac      [ENTRIES];
  logic [IDX_W-1:0]   replace_pointer;

  logic               out_valid;
  logic               out_found;
  logic [47:0]        out_mac;

  logic [ENTRIES-1:0] hit;
  logic               hit_any;
  logic               free_any;
  logic [IDX_W-1:0]   hit_idx;
  logic [IDX_W-1:0]   free_idx;
  logic [IDX_W-1:0]   tgt_idx;
  logic [IDX_W-1:0]   replace_next;

  assign cfg.ready   = 1'b1;
  assign rsp.valid   = out_valid;
  assign rsp.found   = out_found;
  assign rsp.mac_out = out_mac;

  // a lookup is popped only if the response slot is free by the time it runs
  assign q_pop = (state == S_IDLE) && !q_empty &&
                 ((q_data.req_type != REQ_LOOKUP) || !out_valid || rsp.ready);

  always_comb begin
    for (int k = 0; k < ENTRIES; k++) begin
      hit[k] = entry_valid[k] && (entry_ip[k] == op.ip_addr);
    end
  end

  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int k = ENTRIES - 1; k >= 0; k--) begin
      if (hit[k]) begin
        hit_idx = IDX_W'(k);
      end
      if (!entry_valid[k]) begin
        free_idx = IDX_W'(k);
      end
    end
  end

  assign hit_any      = |hit;
  assign free_any     = !(&entry_valid);
  assign tgt_idx      = hit_any ? hit_idx : (free_any ? free_idx : replace_pointer);
  assign replace_next = (replace_pointer == IDX_W'(ENTRIES - 1)) ? '0
                                                                  : replace_pointer + 1'b1;

  // table payload, no reset needed: entries are gated by the valid bits
  always_ff @(posedge clk) begin
    if (state == S_IDLE && q_pop) begin
      op <= q_data;
    end
    if (state == S_EXEC) begin
      case (op.req_type)
        REQ_LEARN: begin
          entry_lifetime[tgt_idx] <= lifetime_reload;
          entry_ip[tgt_idx]       <= op.ip_addr;
          entry_mac[tgt_idx]      <= op.mac_addr;
        end
        REQ_LOOKUP: begin
          out_found <= hit_any;
          out_mac   <= hit_any ? entry_mac[hit_idx] : '0;
        end
        REQ_TICK: begin
          for (int k = 0; k < ENTRIES; k++) begin
            if (entry_valid[k] && (entry_lifetime[k] != '0)) begin
              entry_lifetime[k] <= entry_lifetime[k] - 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      entry_valid     <= '0;
      replace_pointer <= '0;
      out_valid       <= 1'b0;
      lifetime_reload <= LIFETIME_RESET;
    end else begin
      if (cfg.valid) begin
        lifetime_reload <= cfg.data;
      end
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_pop) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_IDLE;
          case (op.req_type)
            REQ_LEARN: begin
              entry_valid[tgt_idx] <= 1'b1;
              if (!hit_any && !free_any) begin
                replace_pointer <= replace_next;
              end
            end
            REQ_LOOKUP: begin
              out_valid <= 1'b1;
            end
            REQ_TICK: begin
              for (int k = 0; k < ENTRIES; k++) begin
                if (entry_valid[k] && (entry_lifetime[k] == '0)) begin
                  entry_valid[k] <= 1'b0;
                end
              end
            end
            default: begin
            end
          endcase
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ARP_ASSERT(a_learn_lands, clk, rst,
    (state == S_EXEC && op.req_type == REQ_LEARN) |=>
    (entry_valid[$past(tgt_idx)] && entry_ip[$past(tgt_idx)] == $past(op.ip_addr)),
    "learned address not present in its entry")
  `ARP_ASSERT(a_rsp_from_lookup, clk, rst,
    $rose(out_valid) |-> $past(state == S_EXEC && op.req_type == REQ_LOOKUP),
    "response raised without a lookup")
  `ARP_ASSERT(a_miss_mac_zero, clk, rst,
    (out_valid && !out_found) |-> (out_mac == '0),
    "miss response carries a nonzero MAC")
  `ARP_ASSERT(a_pop_idle, clk, rst,
    q_pop |-> (state == S_IDLE),
    "queue popped while executing")

endmodule

`default_nettype wire
